/* hw/rtl/least_loaded_object_placer_assert.svh */
// Assertion macros for the least loaded object placer.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef LEAST_LOADED_OBJECT_PLACER_ASSERT_SVH
`define LEAST_LOADED_OBJECT_PLACER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LLOP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llop: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LLOP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llop: assertion failed");

`endif

/* hw/rtl/llop_pkg.sv */
// Shared types and constants for the least loaded object placer.
// Used by the load table and the top level; llop_ram does not use it. Depends on nothing.
`timescale 1ns / 1ps

package llop_pkg;

    // Default sizing, handed down from the top level
    localparam int unsigned NUM_TARGETS_DEF = 2;
    localparam int unsigned DIR_DEPTH_DEF   = 64;

    // Fixed field widths
    localparam int unsigned TAG_W  = 32;
    localparam int unsigned KEY_W  = 64;
    localparam int unsigned SIZE_W = 40;
    localparam int unsigned HASH_W = 64;
    localparam int unsigned LOAD_W = 48;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TAG_W-1:0]  request_tag;
        logic [KEY_W-1:0]  object_key;
        logic [SIZE_W-1:0] size_bytes;
        logic [HASH_W-1:0] content_hash;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]  tag_out;
        logic              was_write;
        logic              target_index;
        logic [HASH_W-1:0] hash_out;
        logic              key_found;
        logic              directory_full;
    } t_out_item;

    // One directory entry as held in the RAM
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              target;
        logic [HASH_W-1:0] hash;
    } t_dir_entry;

    // Sequencer to load table
    typedef struct packed {
        logic              start;
        logic              commit;
        logic [SIZE_W-1:0] size;
    } t_load_ctl;

    // Load table to sequencer
    typedef struct packed {
        logic busy;
        logic best_lsb;
    } t_load_sts;

endpackage

/* hw/rtl/llop_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module llop_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/llop_load_tbl.sv */
// Per-target byte counters with an iterative least-loaded search and saturating update.
// Depends on llop_pkg.
`timescale 1ns / 1ps

module llop_load_tbl #(
    parameter int unsigned NUM_TARGETS = llop_pkg::NUM_TARGETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  llop_pkg::t_load_ctl   i_ctl,
    output llop_pkg::t_load_sts   o_sts
);

    localparam int unsigned IdxW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TARGETS - 1);
    localparam int unsigned LoadW = llop_pkg::LOAD_W;

    logic [LoadW-1:0] r_load [NUM_TARGETS];
    logic [IdxW-1:0]  r_idx;
    logic [IdxW-1:0]  r_best;
    logic [LoadW-1:0] r_best_load;
    logic             r_busy;

    logic [LoadW-1:0] w_cur;
    logic [LoadW:0]   w_sum;
    logic [LoadW-1:0] w_new;

    // One counter read per cycle through the scan index
    assign w_cur = r_load[r_idx];

    // Saturating add of the write size onto the chosen counter
    assign w_sum = {1'b0, r_best_load} + (LoadW + 1)'(i_ctl.size);
    assign w_new = w_sum[LoadW] ? llop_pkg::LOAD_MAX : w_sum[LoadW-1:0];

    // Walk the counters one a cycle, keep the strict minimum, lowest index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_best <= '0;
            for (int i = 0; i < NUM_TARGETS; i++) begin
                r_load[i] <= '0;
            end
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if ((r_idx == '0) || (w_cur < r_best_load)) begin
                    r_best      <= r_idx;
                    r_best_load <= w_cur;
                end
                if (r_idx == LastIdx) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_ctl.commit) begin
                r_load[r_best] <= w_new;
            end
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.best_lsb = r_best[0];

endmodule

/* hw/rtl/least_loaded_object_placer.sv */
// Time from input transfer to result grows with the scan: a hit ends the scan at the
// matching entry, a miss reads every filled entry; a write's result also waits for the
// least-loaded search to finish. One item at a time: the input stalls until the result
// is loaded, and longer while the result side stalls. The scan reads one RAM entry a
// cycle. Reset clears the counters and the fill count at once; the block takes a
// transfer in the first cycle after it.
`timescale 1ns / 1ps
`include "least_loaded_object_placer_assert.svh"

module least_loaded_object_placer #(
    parameter int unsigned NUM_TARGETS = llop_pkg::NUM_TARGETS_DEF,
    parameter int unsigned DIR_DEPTH   = llop_pkg::DIR_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  llop_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output llop_pkg::t_out_item o_out_data
);

    localparam int unsigned AddrW = $clog2(DIR_DEPTH);
    localparam int unsigned FillW = $clog2(DIR_DEPTH + 1);
    localparam logic [FillW-1:0] FillMax = FillW'(DIR_DEPTH);
    localparam int unsigned EntW = $bits(llop_pkg::t_dir_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    llop_pkg::t_in_item       r_item;
    logic [FillW-1:0]         r_addr;
    logic                     r_pend;
    logic [AddrW-1:0]         r_pidx;
    logic                     r_hit;
    logic [AddrW-1:0]         r_slot;
    logic                     r_hit_target;
    logic [llop_pkg::HASH_W-1:0] r_hit_hash;
    logic [FillW-1:0]         r_fill;
    logic                     r_out_valid;
    llop_pkg::t_out_item      r_out;

    logic                     w_accept;
    logic                     w_issue;
    logic                     w_match;
    logic                     w_is_write;
    logic                     w_full;
    logic                     w_go;
    logic                     w_commit;
    logic                     w_new_entry;
    logic [EntW-1:0]          w_rd_raw;
    llop_pkg::t_dir_entry     w_rd_entry;
    llop_pkg::t_dir_entry     w_wr_entry;
    logic [AddrW-1:0]         w_waddr;
    llop_pkg::t_load_ctl      w_load_ctl;
    llop_pkg::t_load_sts      w_load_sts;
    llop_pkg::t_out_item      w_result;

    // Handshake and scan control
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_write  = (r_item.op == llop_pkg::OP_WRITE);
    assign w_full      = (r_fill == FillMax);
    assign w_issue     = (r_state == S_SCAN) && (r_addr < r_fill) && !w_match;
    assign w_rd_entry  = llop_pkg::t_dir_entry'(w_rd_raw);
    assign w_match     = (r_state == S_SCAN) && r_pend
                         && (w_rd_entry.key == r_item.object_key);
    assign w_go        = (r_state == S_FINISH) && !w_load_sts.busy
                         && (!r_out_valid || !i_out_stall);
    assign w_new_entry = w_is_write && !r_hit && !w_full;
    assign w_commit    = w_go && w_is_write && (r_hit || !w_full);

    // Directory write: update in place on a hit, else append at the fill point
    assign w_waddr           = r_hit ? r_slot : r_fill[AddrW-1:0];
    assign w_wr_entry.key    = r_item.object_key;
    assign w_wr_entry.target = w_load_sts.best_lsb;
    assign w_wr_entry.hash   = r_item.content_hash;

    llop_ram #(
        .WIDTH (EntW),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_entry),
        .i_re    (w_issue),
        .i_raddr (r_addr[AddrW-1:0]),
        .o_rdata (w_rd_raw)
    );

    // Least-loaded search runs alongside the directory scan
    assign w_load_ctl.start  = w_accept && (i_in_data.op == llop_pkg::OP_WRITE);
    assign w_load_ctl.commit = w_commit;
    assign w_load_ctl.size   = r_item.size_bytes;

    llop_load_tbl #(
        .NUM_TARGETS (NUM_TARGETS)
    ) u_load_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_load_ctl),
        .o_sts   (w_load_sts)
    );

    // Assemble the result
    always_comb begin
        w_result.tag_out        = r_item.request_tag;
        w_result.was_write      = w_is_write;
        w_result.target_index   = 1'b0;
        w_result.hash_out       = '0;
        w_result.key_found      = 1'b0;
        w_result.directory_full = 1'b0;
        if (w_is_write) begin
            if (r_hit || !w_full) begin
                w_result.target_index = w_load_sts.best_lsb;
            end else begin
                w_result.directory_full = 1'b1;
            end
        end else if (r_hit) begin
            w_result.target_index = r_hit_target;
            w_result.hash_out     = r_hit_hash;
            w_result.key_found    = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match || (!r_pend && (r_addr == r_fill))) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, scan pointers, fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Capture the item and restart the scan
            if (w_accept) begin
                r_item <= i_in_data;
                r_addr <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end

            // Advance the scan, one RAM read a cycle
            if (r_state == S_SCAN) begin
                r_pend <= w_issue;
                r_pidx <= r_addr[AddrW-1:0];
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (w_match) begin
                    r_hit        <= 1'b1;
                    r_slot       <= r_pidx;
                    r_hit_target <= w_rd_entry.target;
                    r_hit_hash   <= w_rd_entry.hash;
                end
            end

            // Load the next result, or drop the current one once taken
            if (w_go) begin
                r_out_valid <= 1'b1;
                r_out       <= w_result;
                if (w_new_entry) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `LLOP_ASSERT_NXT(a_accept_blocks_input, i_clk, i_rst_n, w_accept, o_in_stall)
    `LLOP_ASSERT_IMP(a_drop_only_when_full, i_clk, i_rst_n, o_out_valid && o_out_data.directory_full, o_out_data.was_write && !o_out_data.key_found && (r_fill == FillMax))
    `LLOP_ASSERT_IMP(a_found_only_on_read, i_clk, i_rst_n, o_out_valid && o_out_data.key_found, !o_out_data.was_write)
    `LLOP_ASSERT_NXT(a_fill_never_shrinks, i_clk, i_rst_n, 1'b1, r_fill >= $past(r_fill))

endmodule
